### rtl/core/rsa_pkg.sv
// shared types and constants for the ratio sqrt accumulate block
`timescale 1ns / 1ps
package rsa_pkg;

  localparam int ELEM_W = 16;
  localparam int NUM_W  = 32;
  localparam int Q_W    = 32;
  localparam int TERM_W = 16;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 3;

  // per-lane sequencer phases
  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_SQR,
    L_DEN,
    L_DIV,
    L_ROOT,
    L_DONE
  } lane_st_e;

  // top-level control phases
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_MERGE
  } top_st_e;

endpackage

### rtl/core/rsa_lane.sv
// one lane: squares, ratio by restoring division, integer square root
`timescale 1ns / 1ps
module rsa_lane #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rsa_pkg::ELEM_W-1:0]   u_i,
  input  logic signed [rsa_pkg::ELEM_W-1:0]   v_i,
  output logic        [rsa_pkg::TERM_W-1:0]   term_o,
  output logic                                done_o
);
  import rsa_pkg::*;

  localparam int F2  = 2 * FRAC_BITS;
  localparam int DW  = (((F2 + 1) > (62 - F2)) ? (F2 + 1) : (62 - F2)) + 1;
  localparam int DVW = NUM_W + F2;

  lane_st_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  logic signed [ELEM_W-1:0] u_q, v_q;
  logic [31:0]    uu_q, vv_q;
  logic [30:0]    pm_q;
  logic [NUM_W-1:0] num_q;
  logic [61:0]    p2_q;
  logic [DW-1:0]  den_q, rem_q;
  logic [Q_W-1:0] lo_q;
  logic [17:0]    srem_q;
  logic [TERM_W-1:0] root_q;

  logic signed [31:0] uu_s, vv_s, uv_s, uv_abs;
  logic [DVW-1:0] dvd;
  logic [DW:0]    rsh;
  logic           ge;
  logic [17:0]    sh2, trial;
  logic           ge2;

  // next phase
  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE:  if (start_i) state_d = L_MUL;
      L_MUL:   state_d = L_SQR;
      L_SQR:   state_d = L_DEN;
      L_DEN:   state_d = L_DIV;
      L_DIV:   if (cnt_q == 5'd31) state_d = L_ROOT;
      L_ROOT:  if (cnt_q == 5'd15) state_d = L_DONE;
      L_DONE:  state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  // step counter and done flag
  always_comb begin
    cnt_d  = (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
    done_o = (state_q == L_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath arithmetic
  always_comb begin
    uu_s   = 32'(u_q) * 32'(u_q);
    vv_s   = 32'(v_q) * 32'(v_q);
    uv_s   = 32'(u_q) * 32'(v_q);
    uv_abs = (uv_s < 0) ? -uv_s : uv_s;
    dvd    = DVW'(num_q) << F2;
    rsh    = {rem_q, lo_q[Q_W-1]};
    ge     = (rsh >= {1'b0, den_q});
    sh2    = {srem_q[15:0], lo_q[Q_W-1:Q_W-2]};
    trial  = {root_q, 2'b01};
    ge2    = (sh2 >= trial);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          u_q <= u_i;
          v_q <= v_i;
        end
      end
      L_MUL: begin
        uu_q <= uu_s;
        vv_q <= vv_s;
        pm_q <= uv_abs[30:0];
      end
      L_SQR: begin
        num_q <= uu_q + vv_q;
        p2_q  <= 62'(pm_q) * 62'(pm_q);
      end
      L_DEN: begin
        den_q  <= DW'(p2_q >> F2) + (DW'(1) << F2);
        rem_q  <= DW'(dvd >> Q_W);
        lo_q   <= dvd[Q_W-1:0];
        srem_q <= '0;
        root_q <= '0;
      end
      L_DIV: begin
        rem_q <= ge ? DW'(rsh - {1'b0, den_q}) : rsh[DW-1:0];
        lo_q  <= {lo_q[Q_W-2:0], ge};
      end
      L_ROOT: begin
        srem_q <= ge2 ? (sh2 - trial) : sh2;
        root_q <= {root_q[TERM_W-2:0], ge2};
        lo_q   <= {lo_q[Q_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign term_o = root_q;

endmodule

### rtl/core/rsa_merge.sv
// merges lane terms into the saturating running sum
`timescale 1ns / 1ps
module rsa_merge #(
  parameter int LANES = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [LANES-1:0][rsa_pkg::TERM_W-1:0]  term_i,
  input  logic [LANES-1:0]                       mask_i,
  input  logic                                   add_i,
  input  logic                                   clear_i,
  output logic [rsa_pkg::SUM_W-1:0]              total_o,
  output logic                                   sat_o
);
  import rsa_pkg::*;

  localparam int TS_W = TERM_W + 3;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic             ovf_q, ovf_d;
  logic [TS_W-1:0]  tsum;
  logic [SUM_W:0]   wide;

  // add the masked lane terms, clamp at the top
  always_comb begin
    tsum = '0;
    for (int i = 0; i < LANES; i++) begin
      if (mask_i[i]) tsum = tsum + TS_W'(term_i[i]);
    end
    wide    = {1'b0, sum_q} + (SUM_W + 1)'(tsum);
    total_o = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
    sat_o   = ovf_q | wide[SUM_W];
    sum_d   = clear_i ? '0 : total_o;
    ovf_d   = clear_i ? 1'b0 : sat_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (add_i) begin
      sum_q <= sum_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

### rtl/core/ratio_sqrt_accumulate.sv
// top level: lane array, merge stage and stream handshakes
//
// channel  | dir | content
// s_axis   | in  | tdata: u0..u(L-1), v0..v(L-1), valid_lanes; tlast: last
// m_axis   | out | tdata: total, saturated
//
// each word goes from accept to merge through three setup stages,
// 32 divider steps, 16 square-root steps and a done state in every lane,
// then the merge state; the next word can be taken in the cycle after the
// merge, so no word is accepted while an earlier one is in lanes or merge.
// reset clears the sequencer, the sum and the output valid.
// a result waiting on m_axis does not stop new words; only a second
// result stalls the merge until the first is taken.
`timescale 1ns / 1ps
module ratio_sqrt_accumulate #(
  parameter int LANES     = 4,
  parameter int FRAC_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // u0..u(L-1), v0..v(L-1), valid_lanes, zero pad
  input  logic [((32*LANES+3+7)/8)*8-1:0]        s_axis_tdata_i,
  input  logic                                   s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // total, saturated, zero pad
  output logic [55:0]                            m_axis_tdata_o
);
  import rsa_pkg::*;

  top_st_e state_q, state_d;
  logic    s_acc, emit, add, stall;
  logic    last_q;
  logic [LANES-1:0] mask_q;
  logic [LANES-1:0] lane_done;
  logic [LANES-1:0][TERM_W-1:0] terms;
  logic [CNT_W-1:0] cnt_in, cnt_eff;
  logic [SUM_W-1:0] total;
  logic             sat;
  logic             mvalid_q;
  logic [SUM_W:0]   mdata_q;

  assign s_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign cnt_in = s_axis_tdata_i[32*LANES +: CNT_W];
  assign cnt_eff = (int'(cnt_in) > LANES) ? CNT_W'(LANES) : cnt_in;

  // lane array
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rsa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (s_acc),
      .u_i     (s_axis_tdata_i[ELEM_W*g +: ELEM_W]),
      .v_i     (s_axis_tdata_i[ELEM_W*(LANES+g) +: ELEM_W]),
      .term_o  (terms[g]),
      .done_o  (lane_done[g])
    );
  end

  rsa_merge #(.LANES(LANES)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .term_i  (terms),
    .mask_i  (mask_q),
    .add_i   (add),
    .clear_i (last_q),
    .total_o (total),
    .sat_o   (sat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_acc) state_d = S_RUN;
      S_RUN:   if (lane_done[0]) state_d = S_MERGE;
      S_MERGE: if (!stall) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    stall           = last_q & mvalid_q & ~m_axis_tready_i;
    s_axis_tready_o = (state_q == S_IDLE);
    add             = (state_q == S_MERGE) & ~stall;
    emit            = add & last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) mvalid_q <= 1'b1;
      else if (m_axis_tready_i) mvalid_q <= 1'b0;
    end
  end

  // word side info and result register
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      last_q <= s_axis_tlast_i;
      for (int i = 0; i < LANES; i++) mask_q[i] <= (i < int'(cnt_eff));
    end
    if (emit) mdata_q <= {sat, total};
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {7'd0, mdata_q};

  // lanes run in lockstep
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_done == '0) || (&lane_done))
    else $error("lanes out of step");

  // a flagged result carries the clamped maximum
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[SUM_W]) |-> (&m_axis_tdata_o[SUM_W-1:0]))
    else $error("saturated result not at maximum");

  // no new word while lanes are busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("word taken while busy");

endmodule
